>>> src/esc4w_pkg.sv
// ----------------------------------------------------------------------------
// esc4w_pkg
// Shared constants, types and the CRC16 byte update for the 4-way command
// responder.
// ----------------------------------------------------------------------------
package esc4w_pkg;

    localparam int IDX_W  = 4;     // response byte index, up to 14 bytes
    localparam int ADDR_W = 5;     // four 64-bit registers at 8-byte stride

    localparam logic [7:0] SYNC_RX = 8'h2f;
    localparam logic [7:0] SYNC_TX = 8'h2e;

    localparam logic [7:0] ACK_OK       = 8'h00;
    localparam logic [7:0] ACK_BADCMD   = 8'h02;
    localparam logic [7:0] ACK_BADPARAM = 8'h09;

    localparam logic [7:0] CMD_KEEPALIVE = 8'h30;
    localparam logic [7:0] CMD_PROTO_VER = 8'h31;
    localparam logic [7:0] CMD_NAME      = 8'h32;
    localparam logic [7:0] CMD_VERSION   = 8'h33;
    localparam logic [7:0] CMD_EXIT      = 8'h34;
    localparam logic [7:0] CMD_INIT      = 8'h37;
    localparam logic [7:0] CMD_SET_MODE  = 8'h3f;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Register indexes
    localparam logic [1:0] REG_PROTO_VER = 2'd0;
    localparam logic [1:0] REG_IF_VER    = 2'd1;
    localparam logic [1:0] REG_IF_NAME   = 2'd2;
    localparam logic [1:0] REG_SIGNATURE = 2'd3;

    localparam logic [7:0]  RST_PROTO_VER = 8'd106;
    localparam logic [15:0] RST_IF_VER    = 16'd256;
    localparam logic [47:0] RST_IF_NAME   = 48'd110305219602798;
    localparam logic [15:0] RST_SIGNATURE = 16'd12531;

    typedef struct packed {
        logic             take;   // input beat accepted
        logic             start;  // accepted beat closes a frame
        logic             load;   // load next response byte into output stage
        logic [IDX_W-1:0] idx;    // response byte being loaded
    } esc4w_cmd_t;

    typedef struct packed {
        logic frame_done;  // next accepted byte is the last of a frame
        logic last;        // idx points at the final CRC byte
    } esc4w_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> src/esc4w_ctrl.sv
// ----------------------------------------------------------------------------
// esc4w_ctrl
// Receive/transmit sequencer: takes input beats, then walks the response
// frame byte by byte into the output stage.
// ----------------------------------------------------------------------------
module esc4w_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  esc4w_pkg::esc4w_stat_t  stat,
    output esc4w_pkg::esc4w_cmd_t   cmd
);
    import esc4w_pkg::*;

    localparam logic ST_RX = 1'b0;
    localparam logic ST_TX = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        cmd.take  = (state_reg == ST_RX) && s_valid;
        cmd.start = cmd.take && stat.frame_done;
        cmd.load  = (state_reg == ST_TX) && (!m_valid_reg || m_ready);
        cmd.idx   = idx_reg;

        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_RX: begin
                if (cmd.start) begin
                    state_next = ST_TX;
                    idx_next   = '0;
                end
            end
            ST_TX: begin
                if (cmd.load) begin
                    idx_next = idx_reg + 1'b1;
                    if (stat.last) begin
                        state_next = ST_RX;
                    end
                end
            end
            default: begin
                state_next = ST_RX;
            end
        endcase

        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RX;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_RX);
    assign m_valid = m_valid_reg;

endmodule

>>> src/esc4w_dp.sv
// ----------------------------------------------------------------------------
// esc4w_dp
// Frame parser, configuration registers, response byte builder, running
// CRC16 and the output byte stage.
// ----------------------------------------------------------------------------
module esc4w_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [7:0]                     s_rx_byte,
    output logic [7:0]                     m_tx_byte,
    output logic                           m_frame_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [esc4w_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    input  esc4w_pkg::esc4w_cmd_t          cmd,
    output esc4w_pkg::esc4w_stat_t         stat
);
    import esc4w_pkg::*;

    localparam logic [1:0] PH_SYNC    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Configuration registers
    logic [7:0]  proto_reg;
    logic [15:0] ver_reg;
    logic [47:0] name_reg;
    logic [15:0] sig_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // Parser state
    logic [1:0] phase_reg, phase_next;
    logic [2:0] hc_reg, hc_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [8:0] rem_reg, rem_next;
    logic [7:0] fp_reg, fp_next;
    logic [1:0] mode_reg;
    logic [8:0] rem_dec;
    logic [2:0] hc_inc;

    // Response build
    logic [2:0]      plen;
    logic [7:0]      ack;
    logic [5:0][7:0] pay;
    logic [3:0]      plen_w;
    logic [3:0]      pay_off;
    logic [7:0]      tx_byte;
    logic            crc_upd;
    logic [15:0]     crc_reg;
    logic [7:0]      tx_byte_reg;
    logic            frame_end_reg;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proto_reg <= RST_PROTO_VER;
            ver_reg   <= RST_IF_VER;
            name_reg  <= RST_IF_NAME;
            sig_reg   <= RST_SIGNATURE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PROTO_VER: proto_reg <= pwdata[7:0];
                REG_IF_VER:    ver_reg   <= pwdata[15:0];
                REG_IF_NAME:   name_reg  <= pwdata[47:0];
                REG_SIGNATURE: sig_reg   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PROTO_VER: prdata = {56'd0, proto_reg};
            REG_IF_VER:    prdata = {48'd0, ver_reg};
            REG_IF_NAME:   prdata = {16'd0, name_reg};
            REG_SIGNATURE: prdata = {48'd0, sig_reg};
            default:       prdata = '0;
        endcase
    end

    // Parser
    assign rem_dec = (rem_reg != 9'd0) ? rem_reg - 9'd1 : rem_reg;
    assign hc_inc  = hc_reg + 3'd1;
    assign stat.frame_done = (phase_reg == PH_PAYLOAD) && (rem_dec == 9'd0);

    always_comb begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        fp_next    = fp_reg;
        case (phase_reg)
            PH_HEADER: begin
                if (hc_reg == 3'd0) begin
                    cmd_next = s_rx_byte;
                end
                hc_next = hc_inc;
                if (hc_inc >= 3'd4) begin
                    hc_next    = 3'd4;
                    // length byte of zero means 256
                    rem_next   = ((s_rx_byte == 8'd0) ? 9'd256 : {1'b0, s_rx_byte}) + 9'd2;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (hc_reg == 3'd4) begin
                    fp_next = s_rx_byte;
                    hc_next = 3'd5;
                end
                rem_next = rem_dec;
                if (rem_dec == 9'd0) begin
                    phase_next = PH_SYNC;
                    hc_next    = 3'd0;
                end
            end
            default: begin
                phase_next = PH_SYNC;
                if (s_rx_byte == SYNC_RX) begin
                    phase_next = PH_HEADER;
                    hc_next    = 3'd0;
                    fp_next    = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            hc_reg    <= 3'd0;
            cmd_reg   <= 8'd0;
            rem_reg   <= 9'd0;
            fp_reg    <= 8'd0;
            mode_reg  <= 2'd0;
        end else begin
            if (cmd.take) begin
                phase_reg <= phase_next;
                hc_reg    <= hc_next;
                cmd_reg   <= cmd_next;
                rem_reg   <= rem_next;
                fp_reg    <= fp_next;
            end
            if (cmd.start && cmd_reg == CMD_SET_MODE && fp_reg == 8'h01) begin
                mode_reg <= 2'd1;
            end
        end
    end

    // Response payload and ack by command
    always_comb begin
        plen = 3'd1;
        ack  = ACK_OK;
        pay  = '0;
        case (cmd_reg)
            CMD_KEEPALIVE, CMD_EXIT: begin
            end
            CMD_PROTO_VER: begin
                pay[0] = proto_reg;
            end
            CMD_NAME: begin
                plen = 3'd6;
                for (int k = 0; k < 6; k++) begin
                    pay[k] = name_reg[47 - 8*k -: 8];
                end
            end
            CMD_VERSION: begin
                plen   = 3'd2;
                pay[0] = ver_reg[15:8];
                pay[1] = ver_reg[7:0];
            end
            CMD_INIT: begin
                plen   = 3'd4;
                pay[0] = sig_reg[15:8];
                pay[1] = sig_reg[7:0];
                pay[3] = {6'd0, mode_reg};
            end
            CMD_SET_MODE: begin
                if (fp_reg == 8'h01) begin
                    pay[0] = 8'h01;
                end else begin
                    ack = ACK_BADPARAM;
                end
            end
            default: begin
                ack = ACK_BADCMD;
            end
        endcase
    end

    // Byte at idx: sync, cmd, addr hi, addr lo, len, payload, ack, crc hi, crc lo
    assign plen_w  = {1'b0, plen};
    assign pay_off = cmd.idx - 4'd5;

    always_comb begin
        crc_upd = 1'b1;
        if (cmd.idx == 4'd0) begin
            tx_byte = SYNC_TX;
        end else if (cmd.idx == 4'd1) begin
            tx_byte = cmd_reg;
        end else if (cmd.idx < 4'd4) begin
            tx_byte = 8'd0;
        end else if (cmd.idx == 4'd4) begin
            tx_byte = {5'd0, plen};
        end else if (cmd.idx < 4'd5 + plen_w) begin
            tx_byte = pay[pay_off[2:0]];
        end else if (cmd.idx == 4'd5 + plen_w) begin
            tx_byte = ack;
        end else if (cmd.idx == 4'd6 + plen_w) begin
            tx_byte = crc_reg[15:8];
            crc_upd = 1'b0;
        end else begin
            tx_byte = crc_reg[7:0];
            crc_upd = 1'b0;
        end
    end

    assign stat.last = (cmd.idx == 4'd7 + plen_w);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            crc_reg <= 16'd0;
        end else if (cmd.load && crc_upd) begin
            crc_reg <= crc_byte(crc_reg, tx_byte);
        end
        if (cmd.load) begin
            tx_byte_reg   <= tx_byte;
            frame_end_reg <= stat.last;
        end
    end

    assign m_tx_byte   = tx_byte_reg;
    assign m_frame_end = frame_end_reg;

endmodule

>>> src/esc_4way_command_responder.sv
// ----------------------------------------------------------------------------
// esc_4way_command_responder
// Answers 4-way interface command frames received one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat takes one cycle while the block is receiving. When the
// last CRC byte of a frame is accepted, s_ready drops and the response
// (9 to 14 bytes: 8 plus the payload length) is built one byte per cycle
// into the output stage while it is not stalled, the CRC16 being advanced
// as each byte up to the ack is loaded; s_ready rises again as the final
// byte enters the output stage. Registers sit at byte addresses 0, 8, 16
// and 24 (protocol version, interface version, name, signature), 64 bits
// wide; write them only while no frame is in flight.
module esc_4way_command_responder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_tx_byte,
    output logic                          m_frame_end,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esc4w_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import esc4w_pkg::*;

    esc4w_cmd_t  cmd;
    esc4w_stat_t stat;

    assign pready = 1'b1;

    esc4w_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    esc4w_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_rx_byte   (s_rx_byte),
        .m_tx_byte   (m_tx_byte),
        .m_frame_end (m_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

>>> src/esc4w_checker.sv
// ----------------------------------------------------------------------------
// esc4w_checker
// Port-level checks on the response stream of the command responder.
// ----------------------------------------------------------------------------
module esc4w_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [7:0]                    m_tx_byte,
    input logic                          m_frame_end
);
    import esc4w_pkg::*;

    logic first_reg;

    // Mark the next beat as the opening byte of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            first_reg <= m_frame_end;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_frame_end))
        else $error("response beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_frame_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && first_reg |-> m_tx_byte == SYNC_TX && !m_frame_end)
        else $error("response frame does not open with sync byte");

    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_frame_end |=> m_valid)
        else $error("gap inside a response frame");

    // the final byte may wait in the output stage while input resumes
    a_rx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> !s_ready)
        else $error("input taken inside a response frame");

endmodule

bind esc_4way_command_responder esc4w_checker u_esc4w_checker (.*);
